FILE: design/assert_macros.svh
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/s2c_pkg.sv
// constants, types and month tables for the seconds to calendar date converter
package s2c_pkg;

    // pipeline depth, input register through result register
    localparam int unsigned NUM_STAGES = 7;

    typedef logic [8:0] t_day_of_year;

    // floor(x / 675) for x < 2**25 as (x * RECIP_675) >> 35
    localparam logic [25:0] RECIP_675  = 26'd50903317;
    // floor(x / 1461) for x < 2**16 as (x * RECIP_1461) >> 27
    localparam logic [16:0] RECIP_1461 = 17'd91868;
    // floor(x / 225) for x < 2**13 as (x * RECIP_225) >> 21
    localparam logic [13:0] RECIP_225  = 14'd9321;
    // floor(x / 15) for x < 2**10 as (x * RECIP_15) >> 14
    localparam logic [10:0] RECIP_15   = 11'd1093;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [10:0] DAYS_PER_QUAD = 11'd1461;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

    // day-of-quad boundaries of the second, third and fourth year
    localparam logic [10:0] YEAR1_START = 11'd366;
    localparam logic [10:0] YEAR2_START = 11'd731;
    localparam logic [10:0] YEAR3_START = 11'd1096;

    localparam t_day_of_year MONTH_START_LEAP [0:12] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
        9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
    };
    localparam t_day_of_year MONTH_START_COMMON [0:12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    // first day of month idx (0 is january) within a leap or common year
    function automatic t_day_of_year month_start(input logic leap, input logic [3:0] idx);
        t_day_of_year res;
        res = '0;
        if (idx <= 4'd12) begin
            res = leap ? MONTH_START_LEAP[idx] : MONTH_START_COMMON[idx];
        end
        return res;
    endfunction

endpackage

FILE: design/seconds_to_calendar_date.sv
// seconds since 2000-01-01 00:00:00 to year, month, day and time of day
//
// usage
//   input channel: i_epoch_seconds with i_in_valid / o_in_ready, one timestamp
//   per transfer. output channel: year, month, day, hour, minute, second with
//   o_out_valid / i_out_ready, exactly one result per input transfer, in order.
//   every year whose offset from 2000 is a multiple of four is leap, 2100 too.
// pipeline and throughput
//   seven-stage register pipeline: input register, five work stages, result
//   register. one timestamp per cycle sustained while i_out_ready stays high;
//   the figure is set by the constant-reciprocal multipliers, each followed by
//   a register.
// stalls
//   each stage advances on its own, so bubbles close up while i_out_ready is
//   low; o_in_ready drops only when all seven stages hold an item and the
//   result is not taken. a held result keeps its value until transferred.
// reset
//   i_rst_n is synchronous, active low; it empties the pipeline. no other state.
`include "assert_macros.svh"

module seconds_to_calendar_date (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_year_since_2000,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);

    localparam int unsigned NS = s2c_pkg::NUM_STAGES;

    // per-stage occupancy and flow control
    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] w_src;
    logic [NS-1:0] w_space;
    logic [NS:0]   w_go;     // w_go[k]: stage k loads; w_go[NS]: result transfer

    always_comb begin
        w_src        = {r_vld[NS-2:0], i_in_valid};
        w_go[NS]     = i_out_ready;
        w_space      = '0;
        w_go[NS-1:0] = '0;
        // walk back from the result register so a leaving item frees its slot
        for (int k = NS - 1; k >= 0; k--) begin
            w_space[k] = !r_vld[k] || w_go[k+1];
            w_go[k]    = w_src[k] && w_space[k];
        end
        n_vld = w_go[NS-1:0] | (r_vld & ~w_go[NS:1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = w_space[0];
    assign o_out_valid = r_vld[NS-1];

    // stage 0: input register
    logic [31:0] r0_secs;

    always_ff @(posedge i_clk) begin
        if (w_go[0]) begin
            r0_secs <= i_epoch_seconds;
        end
    end

    // stage 1: whole days, secs / 86400 as (secs >> 7) / 675
    logic [50:0] n1_prod;
    logic [15:0] r1_days;
    logic [16:0] r1_secs_lo;

    assign n1_prod = 51'(r0_secs[31:7]) * 51'(s2c_pkg::RECIP_675);

    always_ff @(posedge i_clk) begin
        if (w_go[1]) begin
            r1_days    <= n1_prod[50:35];
            r1_secs_lo <= r0_secs[16:0];
        end
    end

    // stage 2: seconds of the day and four-year group number
    logic [32:0] n2_day_secs;
    logic [32:0] n2_quad_prod;
    logic [16:0] n2_sod;
    logic [10:0] r2_days_lo;
    logic [5:0]  r2_quad;
    logic [16:0] r2_sod;

    // sod stays below 2**17, so the low bits of the difference are exact
    assign n2_day_secs  = 33'(r1_days) * 33'(s2c_pkg::SECS_PER_DAY);
    assign n2_sod       = r1_secs_lo - n2_day_secs[16:0];
    assign n2_quad_prod = 33'(r1_days) * 33'(s2c_pkg::RECIP_1461);

    always_ff @(posedge i_clk) begin
        if (w_go[2]) begin
            r2_days_lo <= r1_days[10:0];
            r2_quad    <= n2_quad_prod[32:27];
            r2_sod     <= n2_sod;
        end
    end

    // stage 3: day within the group and hour of the day
    logic [16:0] n3_quad_days;
    logic [10:0] n3_dq;
    logic [26:0] n3_hour_prod;
    logic [5:0]  r3_quad;
    logic [10:0] r3_dq;
    logic [11:0] r3_sod_lo;
    logic [4:0]  r3_hour;

    assign n3_quad_days = 17'(r2_quad) * 17'(s2c_pkg::DAYS_PER_QUAD);
    assign n3_dq        = r2_days_lo - n3_quad_days[10:0];
    assign n3_hour_prod = 27'(r2_sod[16:4]) * 27'(s2c_pkg::RECIP_225);

    always_ff @(posedge i_clk) begin
        if (w_go[3]) begin
            r3_quad   <= r2_quad;
            r3_dq     <= n3_dq;
            r3_sod_lo <= r2_sod[11:0];
            r3_hour   <= n3_hour_prod[25:21];
        end
    end

    // stage 4: year within the group, day of year, seconds of the hour
    logic [1:0]  n4_yoff;
    logic        n4_leap;
    logic [10:0] n4_dy;
    logic [16:0] n4_hour_secs;
    logic [11:0] n4_soh;
    logic [7:0]  r4_year;
    logic [8:0]  r4_dy;
    logic        r4_leap;
    logic [11:0] r4_soh;
    logic [4:0]  r4_hour;

    always_comb begin
        if (r3_dq < s2c_pkg::YEAR1_START) begin
            n4_yoff = 2'd0;
            n4_leap = 1'b1;
            n4_dy   = r3_dq;
        end else if (r3_dq < s2c_pkg::YEAR2_START) begin
            n4_yoff = 2'd1;
            n4_leap = 1'b0;
            n4_dy   = r3_dq - s2c_pkg::YEAR1_START;
        end else if (r3_dq < s2c_pkg::YEAR3_START) begin
            n4_yoff = 2'd2;
            n4_leap = 1'b0;
            n4_dy   = r3_dq - s2c_pkg::YEAR2_START;
        end else begin
            n4_yoff = 2'd3;
            n4_leap = 1'b0;
            n4_dy   = r3_dq - s2c_pkg::YEAR3_START;
        end
    end

    assign n4_hour_secs = 17'(r3_hour) * 17'(s2c_pkg::SECS_PER_HOUR);
    assign n4_soh       = r3_sod_lo - n4_hour_secs[11:0];

    always_ff @(posedge i_clk) begin
        if (w_go[4]) begin
            r4_year <= {r3_quad, n4_yoff};
            r4_dy   <= n4_dy[8:0];
            r4_leap <= n4_leap;
            r4_soh  <= n4_soh;
            r4_hour <= r3_hour;
        end
    end

    // stage 5: month by table compare, day of month, minute of the hour
    logic [3:0]  n5_month;
    logic [8:0]  n5_start;
    logic [8:0]  n5_day;
    logic [20:0] n5_min_prod;
    logic [7:0]  r5_year;
    logic [3:0]  r5_month;
    logic [4:0]  r5_day;
    logic [4:0]  r5_hour;
    logic [5:0]  r5_minute;
    logic [5:0]  r5_soh_lo;

    // month starts rise, so counting passed starts gives the month
    always_comb begin
        n5_month = 4'd1;
        for (int i = 1; i < 12; i++) begin
            if (r4_dy >= s2c_pkg::month_start(r4_leap, 4'(i))) begin
                n5_month = n5_month + 4'd1;
            end
        end
    end

    assign n5_start    = s2c_pkg::month_start(r4_leap, n5_month - 4'd1);
    assign n5_day      = r4_dy - n5_start + 9'd1;
    assign n5_min_prod = 21'(r4_soh[11:2]) * 21'(s2c_pkg::RECIP_15);

    always_ff @(posedge i_clk) begin
        if (w_go[5]) begin
            r5_year   <= r4_year;
            r5_month  <= n5_month;
            r5_day    <= n5_day[4:0];
            r5_hour   <= r4_hour;
            r5_minute <= n5_min_prod[19:14];
            r5_soh_lo <= r4_soh[5:0];
        end
    end

    // stage 6: second of the minute, result register
    logic [11:0] n6_min_secs;
    logic [7:0]  r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute;
    logic [5:0]  r_second;

    assign n6_min_secs = 12'(r5_minute) * 12'(s2c_pkg::SECS_PER_MIN);

    always_ff @(posedge i_clk) begin
        if (w_go[6]) begin
            r_year   <= r5_year;
            r_month  <= r5_month;
            r_day    <= r5_day;
            r_hour   <= r5_hour;
            r_minute <= r5_minute;
            r_second <= r5_soh_lo - n6_min_secs[5:0];
        end
    end

    assign o_year_since_2000 = r_year;
    assign o_month           = r_month;
    assign o_day_of_month    = r_day;
    assign o_hour            = r_hour;
    assign o_minute          = r_minute;
    assign o_second          = r_second;

    // checks

    // any empty slot in the pipeline means the input side can take a transfer
    `CHK_IMPLY(a_ready_when_room, i_clk, i_rst_n, !(&r_vld), o_in_ready, "input stalled with room")

    // an item in stage five moves into an empty result register
    `CHK_NEXT(a_fill_output, i_clk, i_rst_n, r_vld[NS-2] && !r_vld[NS-1], o_out_valid, "result not loaded")

    `CHK_IMPLY(a_date_range, i_clk, i_rst_n, o_out_valid, (o_month >= 4'd1) && (o_month <= 4'd12) && (o_day_of_month >= 5'd1) && (o_year_since_2000 <= 8'd136), "date field out of range")

    `CHK_IMPLY(a_time_range, i_clk, i_rst_n, o_out_valid, (o_hour <= 5'd23) && (o_minute <= 6'd59) && (o_second <= 6'd59), "time field out of range")

endmodule
